// File: hdl/pts_pkg.sv
package pts_pkg;

  localparam int TABLE_SLOTS_DEF = 16;
  localparam int ID_BITS_DEF = 16;

  typedef enum logic [2:0] {
    REQ_CREATE   = 3'd0,
    REQ_KILL     = 3'd1,
    REQ_TICK     = 3'd2,
    REQ_COUNT    = 3'd3,
    REQ_INDEX    = 3'd4,
    REQ_SCHEDULE = 3'd5,
    REQ_CURRENT  = 3'd6
  } req_t;

  typedef enum logic [2:0] {
    SLOT_UNUSED   = 3'd0,
    SLOT_READY    = 3'd1,
    SLOT_RUNNING  = 3'd2,
    SLOT_SLEEPING = 3'd3,
    SLOT_KILLED   = 3'd4
  } slot_state_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_MISS      = 2'd1,
    STS_PROTECTED = 2'd2,
    STS_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    QST_NONE     = 2'd0,
    QST_RUNNING  = 2'd1,
    QST_READY    = 2'd2,
    QST_SLEEPING = 2'd3
  } query_state_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_START,
    FSM_READ,
    FSM_EVAL,
    FSM_FINISH
  } fsm_state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic eval;
    logic step;
    logic pass2;
    logic finish;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic need_scan;
    logic hit;
    logic last;
    logic pass;
    logic out_free;
  } sts_t;

  function automatic query_state_t query_code(slot_state_t s);
    query_state_t q;
    case (s)
      SLOT_RUNNING:  q = QST_RUNNING;
      SLOT_READY:    q = QST_READY;
      SLOT_SLEEPING: q = QST_SLEEPING;
      default:       q = QST_NONE;
    endcase
    return q;
  endfunction

endpackage

// File: hdl/pts_ctrl.sv
module pts_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  pts_pkg::sts_t  sts,
  output pts_pkg::cmd_t  cmd
);

  pts_pkg::fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pts_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    req_stall = (state != pts_pkg::FSM_IDLE);
    case (state)
      pts_pkg::FSM_IDLE: begin
        if (req_valid) begin
          cmd.load = 1'b1;
          state_next = pts_pkg::FSM_START;
        end
      end
      pts_pkg::FSM_START: begin
        state_next = sts.need_scan ? pts_pkg::FSM_READ : pts_pkg::FSM_FINISH;
      end
      pts_pkg::FSM_READ: begin
        cmd.rd = 1'b1;
        state_next = pts_pkg::FSM_EVAL;
      end
      pts_pkg::FSM_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.hit) begin
          state_next = pts_pkg::FSM_FINISH;
        end else if (sts.last) begin
          // Scheduling falls back to a second pass that looks for the kernel.
          if (sts.req == pts_pkg::REQ_SCHEDULE && !sts.pass) begin
            cmd.pass2 = 1'b1;
            state_next = pts_pkg::FSM_READ;
          end else begin
            state_next = pts_pkg::FSM_FINISH;
          end
        end else begin
          cmd.step = 1'b1;
          state_next = pts_pkg::FSM_READ;
        end
      end
      pts_pkg::FSM_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = pts_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = pts_pkg::FSM_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> state == pts_pkg::FSM_START)
    else $error("accepted request did not start processing");

  a_hit_finishes: assert property (@(posedge clk) disable iff (rst)
    (state == pts_pkg::FSM_EVAL && sts.hit) |=> state == pts_pkg::FSM_FINISH)
    else $error("scan continued past a matching slot");

endmodule

// File: hdl/pts_datapath.sv
module pts_datapath #(
  parameter int TABLE_SLOTS = pts_pkg::TABLE_SLOTS_DEF,
  parameter int ID_BITS = pts_pkg::ID_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  pts_pkg::cmd_t  cmd,
  output pts_pkg::sts_t  sts,
  input  logic [2:0]     req_type,
  input  logic [15:0]    target_id,
  input  logic [3:0]     live_index,
  input  logic           res_stall,
  output logic           res_valid,
  output logic [1:0]     status,
  output logic [15:0]    id_out,
  output logic [4:0]     live_count,
  output logic [1:0]     state_out,
  output logic [31:0]    ticks_out
);

  localparam int IDXW = $clog2(TABLE_SLOTS);
  localparam int CNTW = $clog2(TABLE_SLOTS + 1);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_SLOTS - 1);

  // Tables: one write and one registered read per cycle each.
  logic [ID_BITS-1:0]   id_mem [TABLE_SLOTS];
  pts_pkg::slot_state_t st_mem [TABLE_SLOTS];
  logic [31:0]          tk_mem [TABLE_SLOTS];

  // An entry that was never written reads as its reset value.
  logic [TABLE_SLOTS-1:0] id_vld, st_vld, tk_vld;

  logic [ID_BITS-1:0]   rd_id;
  pts_pkg::slot_state_t rd_st;
  logic [31:0]          rd_tk;
  logic                 rd_id_vld, rd_st_vld, rd_tk_vld;

  logic [IDXW-1:0]      idx;
  logic                 pass, seen;
  logic [CNTW-1:0]      n, live;
  logic [ID_BITS:0]     next_id;
  logic [ID_BITS-1:0]   running_id;

  pts_pkg::req_t        req;
  logic [15:0]          tgt;
  logic [3:0]           want;

  pts_pkg::status_t     res_status;
  logic [15:0]          res_id;
  pts_pkg::query_state_t res_state;
  logic [31:0]          res_ticks;

  logic [ID_BITS-1:0]   eff_id;
  pts_pkg::slot_state_t eff_st;
  logic [31:0]          eff_tk;
  logic                 eff_live, exhausted, kernel_tgt, hit;
  logic [31:0]          eff_id_w, run_w;

  logic                 id_we, st_we, tk_we;
  pts_pkg::slot_state_t st_wd;
  logic [31:0]          tk_wd;

  always_comb begin
    eff_id = rd_id_vld ? rd_id : ((idx == '0) ? ID_BITS'(1) : '0);
    eff_st = rd_st_vld ? rd_st :
             ((idx == '0) ? pts_pkg::SLOT_RUNNING : pts_pkg::SLOT_UNUSED);
    eff_tk = rd_tk_vld ? rd_tk : 32'd0;
    eff_id_w = 32'(eff_id);
    run_w = 32'(running_id);
    eff_live = (eff_st != pts_pkg::SLOT_UNUSED) && (eff_st != pts_pkg::SLOT_KILLED);
    exhausted = next_id[ID_BITS];
    kernel_tgt = (tgt == 16'd1);
  end

  always_comb begin
    hit = 1'b0;
    case (req)
      pts_pkg::REQ_CREATE: hit = (eff_st == pts_pkg::SLOT_UNUSED);
      pts_pkg::REQ_KILL:
        hit = (eff_st != pts_pkg::SLOT_UNUSED) && (eff_id_w == 32'(tgt));
      pts_pkg::REQ_INDEX: hit = eff_live && (32'(n) == 32'(want));
      pts_pkg::REQ_SCHEDULE: begin
        if (pass) begin
          hit = (eff_id_w == 32'd1) && (eff_st != pts_pkg::SLOT_KILLED);
        end else begin
          hit = (eff_st == pts_pkg::SLOT_READY) && seen;
        end
      end
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    sts.req = req;
    sts.hit = hit;
    sts.last = (idx == LAST_IDX);
    sts.pass = pass;
    sts.out_free = !res_valid || !res_stall;
    case (req)
      pts_pkg::REQ_CREATE: sts.need_scan = !exhausted;
      pts_pkg::REQ_KILL, pts_pkg::REQ_TICK, pts_pkg::REQ_INDEX,
      pts_pkg::REQ_SCHEDULE: sts.need_scan = 1'b1;
      default: sts.need_scan = 1'b0;
    endcase
  end

  always_comb begin
    id_we = 1'b0;
    st_we = 1'b0;
    tk_we = 1'b0;
    st_wd = pts_pkg::SLOT_RUNNING;
    tk_wd = 32'd0;
    if (cmd.eval) begin
      case (req)
        pts_pkg::REQ_CREATE: begin
          if (hit) begin
            id_we = 1'b1;
            st_we = 1'b1;
            st_wd = pts_pkg::SLOT_READY;
            tk_we = 1'b1;
          end
        end
        pts_pkg::REQ_KILL: begin
          if (hit && !kernel_tgt) begin
            st_we = 1'b1;
            st_wd = pts_pkg::SLOT_KILLED;
          end
        end
        pts_pkg::REQ_TICK: begin
          if (eff_st == pts_pkg::SLOT_RUNNING) begin
            tk_we = 1'b1;
            tk_wd = eff_tk + 32'd1;
          end
        end
        pts_pkg::REQ_SCHEDULE: begin
          if (hit) begin
            st_we = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (id_we) id_mem[idx] <= next_id[ID_BITS-1:0];
    if (st_we) st_mem[idx] <= st_wd;
    if (tk_we) tk_mem[idx] <= tk_wd;
    if (cmd.rd) begin
      rd_id <= id_mem[idx];
      rd_st <= st_mem[idx];
      rd_tk <= tk_mem[idx];
      rd_id_vld <= id_vld[idx];
      rd_st_vld <= st_vld[idx];
      rd_tk_vld <= tk_vld[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_vld <= '0;
      st_vld <= '0;
      tk_vld <= '0;
    end else begin
      if (id_we) id_vld[idx] <= 1'b1;
      if (st_we) st_vld[idx] <= 1'b1;
      if (tk_we) tk_vld[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      pass <= 1'b0;
      seen <= 1'b0;
      n <= '0;
      next_id <= (ID_BITS + 1)'(2);
      running_id <= ID_BITS'(1);
      live <= CNTW'(1);
      res_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx <= '0;
        pass <= 1'b0;
        seen <= 1'b0;
        n <= '0;
      end
      if (cmd.step) idx <= idx + IDXW'(1);
      if (cmd.pass2) begin
        idx <= '0;
        pass <= 1'b1;
      end
      if (cmd.eval) begin
        case (req)
          pts_pkg::REQ_CREATE: begin
            if (hit) begin
              next_id <= next_id + (ID_BITS + 1)'(1);
              live <= live + CNTW'(1);
            end
          end
          pts_pkg::REQ_KILL: begin
            if (hit && !kernel_tgt && eff_st != pts_pkg::SLOT_KILLED) begin
              live <= live - CNTW'(1);
            end
          end
          pts_pkg::REQ_INDEX: begin
            if (eff_live && !hit) n <= n + CNTW'(1);
          end
          pts_pkg::REQ_SCHEDULE: begin
            if (hit) begin
              running_id <= pass ? ID_BITS'(1) : eff_id;
            end else if (!pass && eff_st == pts_pkg::SLOT_READY) begin
              seen <= 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd.finish) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= pts_pkg::req_t'(req_type);
      tgt <= target_id;
      want <= live_index;
      res_id <= '0;
      res_state <= pts_pkg::QST_NONE;
      res_ticks <= '0;
      case (pts_pkg::req_t'(req_type))
        pts_pkg::REQ_CREATE:
          res_status <= exhausted ? pts_pkg::STS_EXHAUSTED : pts_pkg::STS_MISS;
        pts_pkg::REQ_KILL, pts_pkg::REQ_INDEX: res_status <= pts_pkg::STS_MISS;
        default: res_status <= pts_pkg::STS_OK;
      endcase
    end
    if (cmd.eval && hit) begin
      case (req)
        pts_pkg::REQ_CREATE: begin
          res_status <= pts_pkg::STS_OK;
          res_id <= 16'(32'(next_id[ID_BITS-1:0]));
        end
        pts_pkg::REQ_KILL: begin
          res_status <= kernel_tgt ? pts_pkg::STS_PROTECTED : pts_pkg::STS_OK;
        end
        pts_pkg::REQ_INDEX: begin
          res_status <= pts_pkg::STS_OK;
          res_id <= eff_id_w[15:0];
          res_state <= pts_pkg::query_code(eff_st);
          res_ticks <= eff_tk;
        end
        default: ;
      endcase
    end
    if (cmd.finish) begin
      status <= res_status;
      id_out <= (req == pts_pkg::REQ_SCHEDULE || req == pts_pkg::REQ_CURRENT) ?
                run_w[15:0] : res_id;
      live_count <= (32'(live) > 32'd31) ? 5'd31 : 5'(live);
      state_out <= res_state;
      ticks_out <= res_ticks;
    end
  end

  a_create_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.eval && req == pts_pkg::REQ_CREATE && hit) |=> live == $past(live) + CNTW'(1))
    else $error("create did not raise the live count");

  a_create_ids_left: assert property (@(posedge clk) disable iff (rst)
    (cmd.eval && req == pts_pkg::REQ_CREATE) |-> !exhausted)
    else $error("table scanned for create with ids exhausted");

endmodule

// File: hdl/process_table_scheduler_unit.sv
// Process table scheduler: a table of TABLE_SLOTS entries (id, state, tick count)
// with one request in and one result out per transfer. Count and current-id
// requests go from START straight to FINISH without a table scan; create, kill,
// tick, index query and schedule walk the table one slot at a time (create only
// while ids are left), with a registered table read (READ) and then evaluate
// and write back (EVAL) for each slot; schedule makes a second pass from slot 0
// when it falls back to the kernel, which always sits in slot 0. The single
// read port of each table sets this pace. A new request is taken while a
// result still waits in the output register. Reset takes effect at once;
// there is no clearing pass.
module process_table_scheduler_unit #(
  parameter int TABLE_SLOTS = pts_pkg::TABLE_SLOTS_DEF,
  parameter int ID_BITS = pts_pkg::ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  req_type,
  input  logic [15:0] target_id,
  input  logic [3:0]  live_index,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  status,
  output logic [15:0] id_out,
  output logic [4:0]  live_count,
  output logic [1:0]  state_out,
  output logic [31:0] ticks_out
);

  pts_pkg::cmd_t cmd;
  pts_pkg::sts_t sts;

  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pts_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .ID_BITS     (ID_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_type   (req_type),
    .target_id  (target_id),
    .live_index (live_index),
    .res_stall  (res_stall),
    .res_valid  (res_valid),
    .status     (status),
    .id_out     (id_out),
    .live_count (live_count),
    .state_out  (state_out),
    .ticks_out  (ticks_out)
  );

endmodule
